/* rtl/ttps_pkg.sv */
// Package for the transposition table probe/store unit.
// Field widths, body layout, register indexes and operation codes.
// No dependencies; imported by the interfaces and the top level.
package ttps_pkg;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int PLY_W   = 7;
    localparam int SCORE_W = 16;
    localparam int BOUND_W = 2;
    localparam int SQ_W    = 6;
    localparam int PROMO_W = 4;
    localparam int MBITS_W = 3;
    localparam int GEN_W   = 8;
    localparam int THR_W   = 15;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Body layout, from bit 0 upward.
    localparam int SH_FROM  = 0;
    localparam int SH_TO    = 6;
    localparam int SH_PROMO = 12;
    localparam int SH_BITS  = 16;
    localparam int SH_SCORE = 19;
    localparam int SH_DEPTH = 35;
    localparam int SH_FLAG  = 43;
    localparam int SH_GEN   = 45;
    localparam int BODY_W   = 53;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_GENERATION     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_ALWAYS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATE_THRESHOLD = 2'd2;

    localparam logic [GEN_W-1:0] GEN_RESET = 8'd1;
    localparam logic [THR_W-1:0] THR_RESET = 15'd29000;

    // Operation codes.
    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Bound flag codes.
    localparam logic [BOUND_W-1:0] FLAG_NONE  = 2'd0;
    localparam logic [BOUND_W-1:0] FLAG_EXACT = 2'd1;
    localparam logic [BOUND_W-1:0] FLAG_LOWER = 2'd2;
    localparam logic [BOUND_W-1:0] FLAG_UPPER = 2'd3;

endpackage

/* rtl/ttps_if.sv */
// Handshake interfaces for the transposition table probe/store unit:
// request channel, result channel and configuration write channel.
// Depends on ttps_pkg for the field widths.
interface ttps_req_if
    import ttps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [KEY_W-1:0]          key;
    logic signed [DEPTH_W-1:0] depth;
    logic [PLY_W-1:0]          ply;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [SQ_W-1:0]           move_from;
    logic [SQ_W-1:0]           move_to;
    logic [PROMO_W-1:0]        move_promo;
    logic [MBITS_W-1:0]        move_bits;

    modport source (
        output valid, op, key, depth, ply, alpha, beta, score, bound,
               move_from, move_to, move_promo, move_bits,
        input  ready
    );
    modport sink (
        input  valid, op, key, depth, ply, alpha, beta, score, bound,
               move_from, move_to, move_promo, move_bits,
        output ready
    );
endinterface

interface ttps_rsp_if
    import ttps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      cutoff;
    logic signed [SCORE_W-1:0] score_out;
    logic                      move_found;
    logic [SQ_W-1:0]           found_from;
    logic [SQ_W-1:0]           found_to;
    logic [PROMO_W-1:0]        found_promo;
    logic [MBITS_W-1:0]        found_bits;
    logic                      store_taken;

    modport source (
        output valid, cutoff, score_out, move_found, found_from, found_to,
               found_promo, found_bits, store_taken,
        input  ready
    );
    modport sink (
        input  valid, cutoff, score_out, move_found, found_from, found_to,
               found_promo, found_bits, store_taken,
        output ready
    );
endinterface

interface ttps_cfg_if
    import ttps_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/ttps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the key and body stores; no dependencies.
module ttps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/transposition_table_probe_store_unit.sv */
// Top level of the transposition table probe/store unit.
// Depends on ttps_pkg, the interfaces in ttps_if.sv and ttps_ram.
//
//   Channel   Direction  Moves one transaction of
//   i_req     in         probe or store request (op, key, window, move)
//   o_rsp     out        result (cutoff, score, stored move, store_taken)
//   i_cfg     in         register write (generation, replace_always, threshold)
//
// On acceptance the read of the entry is issued; in the lookup state, once the
// result register has room, the entry is evaluated, a store is written back and
// the result register is loaded. One request is in flight at a time.
// After reset a clearing pass writes zero to every entry, during which no
// request is accepted; configuration writes are taken always.
// A full result register that is not taken holds the evaluation stage.
module transposition_table_probe_store_unit
    import ttps_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttps_req_if.sink   i_req,
    ttps_rsp_if.source o_rsp,
    ttps_cfg_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [GEN_W-1:0] r_generation;
    logic             r_replace_always;
    logic [THR_W-1:0] r_mate_thr;

    // Clearing pass address.
    logic [IDX_W-1:0] r_clr_addr;

    // Captured request.
    logic                      r_op;
    logic [KEY_W-1:0]          r_key;
    logic signed [DEPTH_W-1:0] r_depth;
    logic [PLY_W-1:0]          r_ply;
    logic signed [SCORE_W-1:0] r_alpha;
    logic signed [SCORE_W-1:0] r_beta;
    logic signed [SCORE_W-1:0] r_score;
    logic [BOUND_W-1:0]        r_bound;
    logic [SQ_W-1:0]           r_mfrom;
    logic [SQ_W-1:0]           r_mto;
    logic [PROMO_W-1:0]        r_mpromo;
    logic [MBITS_W-1:0]        r_mbits;

    // Result register.
    logic                      r_out_valid;
    logic                      r_cutoff;
    logic signed [SCORE_W-1:0] r_score_out;
    logic                      r_move_found;
    logic [SQ_W-1:0]           r_found_from;
    logic [SQ_W-1:0]           r_found_to;
    logic [PROMO_W-1:0]        r_found_promo;
    logic [MBITS_W-1:0]        r_found_bits;
    logic                      r_store_taken;

    // Memory ports.
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_waddr;
    logic [KEY_W-1:0]  w_key_wdata;
    logic [BODY_W-1:0] w_body_wdata;
    logic              w_mem_re;
    logic [KEY_W-1:0]  w_ekey;
    logic [BODY_W-1:0] w_ebody;

    logic w_accept;
    logic w_fire;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    // The evaluation stage completes when the result register has room.
    assign w_fire      = (r_state == ST_LOOKUP) && (!r_out_valid || o_rsp.ready);
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Fields of the stored entry.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]           w_e_from;
    logic [SQ_W-1:0]           w_e_to;
    logic [PROMO_W-1:0]        w_e_promo;
    logic [MBITS_W-1:0]        w_e_bits;
    logic signed [SCORE_W-1:0] w_e_score;
    logic [DEPTH_W-1:0]        w_e_depth;
    logic [BOUND_W-1:0]        w_e_flag;
    logic [GEN_W-1:0]          w_e_gen;

    assign w_e_from  = w_ebody[SH_FROM  +: SQ_W];
    assign w_e_to    = w_ebody[SH_TO    +: SQ_W];
    assign w_e_promo = w_ebody[SH_PROMO +: PROMO_W];
    assign w_e_bits  = w_ebody[SH_BITS  +: MBITS_W];
    assign w_e_score = $signed(w_ebody[SH_SCORE +: SCORE_W]);
    assign w_e_depth = w_ebody[SH_DEPTH +: DEPTH_W];
    assign w_e_flag  = w_ebody[SH_FLAG  +: BOUND_W];
    assign w_e_gen   = w_ebody[SH_GEN   +: GEN_W];

    // ------------------------------------------------------------------
    // Evaluation of the entry against the captured request.
    // ------------------------------------------------------------------
    logic signed [DEPTH_W:0]   w_sdepth;   // stored depth is unsigned
    logic signed [DEPTH_W:0]   w_rdepth;
    logic signed [SCORE_W:0]   w_thr;
    logic signed [SCORE_W:0]   w_neg_thr;
    logic signed [SCORE_W:0]   w_ply;
    logic signed [SCORE_W:0]   w_es;
    logic signed [SCORE_W:0]   w_ps;       // probe score after mate adjust
    logic signed [SCORE_W:0]   w_ss;       // store score after mate adjust
    logic signed [SCORE_W:0]   w_rs;
    logic                      w_hit;
    logic                      w_move_valid;
    logic                      w_deep;
    logic                      w_cut;
    logic                      w_refuse;
    logic [DEPTH_W-1:0]        w_store_depth;
    logic [BODY_W-1:0]         w_new_body;

    assign w_sdepth  = $signed({1'b0, w_e_depth});
    assign w_rdepth  = $signed({r_depth[DEPTH_W-1], r_depth});
    assign w_thr     = $signed({2'b00, r_mate_thr});
    assign w_neg_thr = -w_thr;
    assign w_ply     = $signed({{(SCORE_W + 1 - PLY_W){1'b0}}, r_ply});
    assign w_es      = $signed({w_e_score[SCORE_W-1], w_e_score});
    assign w_rs      = $signed({r_score[SCORE_W-1], r_score});

    assign w_hit        = (w_ekey == r_key);
    assign w_move_valid = (w_e_from != w_e_to) || (w_e_promo != '0) || (w_e_bits != '0);
    assign w_deep       = (w_sdepth >= w_rdepth);

    // A probe pulls mate scores toward zero by the ply distance.
    always_comb begin
        if (w_es > w_thr) begin
            w_ps = w_es - w_ply;
        end else if (w_es < w_neg_thr) begin
            w_ps = w_es + w_ply;
        end else begin
            w_ps = w_es;
        end
    end

    // A store pushes mate scores away from zero by the ply distance.
    always_comb begin
        if (w_rs > w_thr) begin
            w_ss = w_rs + w_ply;
        end else if (w_rs < w_neg_thr) begin
            w_ss = w_rs - w_ply;
        end else begin
            w_ss = w_rs;
        end
    end

    always_comb begin
        case (w_e_flag)
            FLAG_EXACT: w_cut = 1'b1;
            FLAG_LOWER: w_cut = (w_ps >= $signed({r_beta[SCORE_W-1], r_beta}));
            FLAG_UPPER: w_cut = (w_ps <= $signed({r_alpha[SCORE_W-1], r_alpha}));
            default:    w_cut = 1'b0;
        endcase
    end

    // A store is refused only for a different, occupied, current-generation
    // entry that was searched deeper than this request.
    assign w_refuse = !r_replace_always && !w_hit && (w_ekey != '0)
                   && (w_e_gen == r_generation) && (w_sdepth > w_rdepth);

    assign w_store_depth = r_depth[DEPTH_W-1] ? '0 : r_depth;

    always_comb begin
        w_new_body = '0;
        w_new_body[SH_FROM  +: SQ_W]    = r_mfrom;
        w_new_body[SH_TO    +: SQ_W]    = r_mto;
        w_new_body[SH_PROMO +: PROMO_W] = r_mpromo;
        w_new_body[SH_BITS  +: MBITS_W] = r_mbits;
        w_new_body[SH_SCORE +: SCORE_W] = w_ss[SCORE_W-1:0];
        w_new_body[SH_DEPTH +: DEPTH_W] = w_store_depth;
        w_new_body[SH_FLAG  +: BOUND_W] = r_bound;
        w_new_body[SH_GEN   +: GEN_W]   = r_generation;
    end

    // ------------------------------------------------------------------
    // Memory access: the clearing pass and store write-back share the
    // write port; the read port is used at request acceptance.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_mem_we     = 1'b1;
            w_mem_waddr  = r_clr_addr;
            w_key_wdata  = '0;
            w_body_wdata = '0;
        end else begin
            w_mem_we     = w_fire && (r_op == OP_STORE) && !w_refuse;
            w_mem_waddr  = r_key[IDX_W-1:0];
            w_key_wdata  = r_key;
            w_body_wdata = w_new_body;
        end
    end

    assign w_mem_re = w_accept;

    ttps_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_key_wdata),
        .i_re    (w_mem_re),
        .i_raddr (i_req.key[IDX_W-1:0]),
        .o_rdata (w_ekey)
    );

    ttps_ram #(
        .WIDTH (BODY_W),
        .DEPTH (ENTRIES)
    ) u_body_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_body_wdata),
        .i_re    (w_mem_re),
        .i_raddr (i_req.key[IDX_W-1:0]),
        .o_rdata (w_ebody)
    );

    // ------------------------------------------------------------------
    // Control.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers; a write beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_generation     <= GEN_RESET;
            r_replace_always <= 1'b0;
            r_mate_thr       <= THR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_GENERATION:     r_generation     <= i_cfg.data[GEN_W-1:0];
                CFG_REPLACE_ALWAYS: r_replace_always <= i_cfg.data[0];
                CFG_MATE_THRESHOLD: r_mate_thr       <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_req.op;
            r_key    <= i_req.key;
            r_depth  <= i_req.depth;
            r_ply    <= i_req.ply;
            r_alpha  <= i_req.alpha;
            r_beta   <= i_req.beta;
            r_score  <= i_req.score;
            r_bound  <= i_req.bound;
            r_mfrom  <= i_req.move_from;
            r_mto    <= i_req.move_to;
            r_mpromo <= i_req.move_promo;
            r_mbits  <= i_req.move_bits;
        end
    end

    // Result payload. A probe reports a valid stored move on a key match and the score
    // only when the stored depth also suffices; a store reports store_taken.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cutoff      <= 1'b0;
            r_score_out   <= '0;
            r_move_found  <= 1'b0;
            r_found_from  <= '0;
            r_found_to    <= '0;
            r_found_promo <= '0;
            r_found_bits  <= '0;
            r_store_taken <= 1'b0;
            if (r_op == OP_STORE) begin
                r_store_taken <= !w_refuse;
            end else if (w_hit) begin
                if (w_move_valid) begin
                    r_move_found  <= 1'b1;
                    r_found_from  <= w_e_from;
                    r_found_to    <= w_e_to;
                    r_found_promo <= w_e_promo;
                    r_found_bits  <= w_e_bits;
                end
                if (w_deep) begin
                    r_score_out <= w_ps[SCORE_W-1:0];
                    r_cutoff    <= w_cut;
                end
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.cutoff      = r_cutoff;
    assign o_rsp.score_out   = r_score_out;
    assign o_rsp.move_found  = r_move_found;
    assign o_rsp.found_from  = r_found_from;
    assign o_rsp.found_to    = r_found_to;
    assign o_rsp.found_promo = r_found_promo;
    assign o_rsp.found_bits  = r_found_bits;
    assign o_rsp.store_taken = r_store_taken;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready
    ) else $error("request accepted during clearing pass");

    a_accept_starts_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOOKUP)
    ) else $error("accepted request did not enter lookup");

    a_result_from_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_LOOKUP)
    ) else $error("result appeared without a lookup");

    a_result_kinds_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_store_taken && (r_cutoff || r_move_found))
    ) else $error("result mixes store and probe fields");

endmodule
